@@ src/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);

`endif

@@ src/vdsf_pkg.sv @@
package vdsf_pkg;

    localparam int NORMAL_ENTRIES = 256;
    localparam int NORMAL_DEFINED = 162;
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        REG_SCALE_X  = 3'd0,
        REG_SCALE_Y  = 3'd1,
        REG_SCALE_Z  = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_OFFSET_Z = 3'd5,
        REG_SNAP     = 3'd6,
        REG_RECIP    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        run_start;
        logic        fan_mode;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
        logic [7:0]  packed_x;
        logic [7:0]  packed_y;
        logic [7:0]  packed_z;
        logic [7:0]  normal_index;
    } in_item_t;

    typedef struct packed {
        logic [16:0]        out_s;
        logic [16:0]        out_t;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               tri_last;
    } out_item_t;

    // decoded vertex as held by the back end
    typedef struct packed {
        logic [16:0]        s;
        logic [16:0]        t;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
    } vert_t;

    typedef struct packed {
        logic  first;
        logic  fan;
        vert_t v;
    } q_item_t;

    typedef struct packed {
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic [6:0]         snap_step;
        logic [23:0]        unit_recip;
    } cfg_t;

    typedef enum logic [1:0] {
        FE_IDLE  = 2'd0,
        FE_SCALE = 2'd1,
        FE_RECIP = 2'd2,
        FE_PUSH  = 2'd3
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE = 2'd0,
        BE_V0   = 2'd1,
        BE_V1   = 2'd2,
        BE_V2   = 2'd3
    } be_state_t;

    localparam logic [14:0] VA = 15'd2419;
    localparam logic [14:0] VB = 15'd2662;
    localparam logic [14:0] VC = 15'd3913;
    localparam logic [14:0] VD = 15'd4307;
    localparam logic [14:0] VE = 15'd4837;
    localparam logic [14:0] VF = 15'd5063;
    localparam logic [14:0] VG = 15'd6969;
    localparam logic [14:0] VH = 15'd7256;
    localparam logic [14:0] VI = 15'd8192;
    localparam logic [14:0] VJ = 15'd8614;
    localparam logic [14:0] VK = 15'd9630;
    localparam logic [14:0] VL = 15'd11169;
    localparam logic [14:0] VM = 15'd11275;
    localparam logic [14:0] VN = 15'd11740;
    localparam logic [14:0] VO = 15'd13255;
    localparam logic [14:0] VP = 15'd13937;
    localparam logic [14:0] VQ = 15'd14159;
    localparam logic [14:0] VR = 15'd15582;
    localparam logic [14:0] VS = 15'd15654;
    localparam logic [14:0] VU = 15'd16384;
    localparam logic [14:0] V0 = 15'd0;

    function automatic logic signed [15:0] p(input logic [14:0] m);
        p = signed'({1'b0, m});
    endfunction

    function automatic logic signed [15:0] n(input logic [14:0] m);
        n = -signed'({1'b0, m});
    endfunction

    // normal table, entries {x, y, z}
    function automatic logic [47:0] normal_lookup(input logic [7:0] idx);
        logic [47:0] r;
        r = '0;
        case (idx)
            8'd0: r = {n(VJ),p(V0),p(VP)};
            8'd1: r = {n(VH),p(VC),p(VQ)};
            8'd2: r = {n(VE),p(V0),p(VS)};
            8'd3: r = {n(VF),p(VI),p(VO)};
            8'd4: r = {n(VB),p(VD),p(VR)};
            8'd5: r = {p(V0),p(V0),p(VU)};
            8'd6: r = {p(V0),p(VP),p(VJ)};
            8'd7: r = {n(VA),p(VN),p(VL)};
            8'd8: r = {p(VA),p(VN),p(VL)};
            8'd9: r = {p(V0),p(VJ),p(VP)};
            8'd10: r = {p(VF),p(VI),p(VO)};
            8'd11: r = {p(VJ),p(V0),p(VP)};
            8'd12: r = {p(VE),p(V0),p(VS)};
            8'd13: r = {p(VH),p(VC),p(VQ)};
            8'd14: r = {p(VB),p(VD),p(VR)};
            8'd15: r = {n(VL),p(VA),p(VN)};
            8'd16: r = {n(VO),p(VF),p(VI)};
            8'd17: r = {n(VK),p(VG),p(VM)};
            8'd18: r = {n(VP),p(VJ),p(V0)};
            8'd19: r = {n(VQ),p(VH),p(VC)};
            8'd20: r = {n(VN),p(VL),p(VA)};
            8'd21: r = {n(VM),p(VK),p(VG)};
            8'd22: r = {n(VI),p(VO),p(VF)};
            8'd23: r = {n(VC),p(VQ),p(VH)};
            8'd24: r = {n(VG),p(VM),p(VK)};
            8'd25: r = {n(VN),p(VL),n(VA)};
            8'd26: r = {n(VI),p(VO),n(VF)};
            8'd27: r = {n(VJ),p(VP),p(V0)};
            8'd28: r = {p(V0),p(VP),n(VJ)};
            8'd29: r = {n(VC),p(VQ),n(VH)};
            8'd30: r = {p(V0),p(VS),n(VE)};
            8'd31: r = {n(VD),p(VR),n(VB)};
            8'd32: r = {p(V0),p(VU),p(V0)};
            8'd33: r = {p(V0),p(VS),p(VE)};
            8'd34: r = {n(VD),p(VR),p(VB)};
            8'd35: r = {p(VC),p(VQ),p(VH)};
            8'd36: r = {p(VD),p(VR),p(VB)};
            8'd37: r = {p(VI),p(VO),p(VF)};
            8'd38: r = {p(VC),p(VQ),n(VH)};
            8'd39: r = {p(VD),p(VR),n(VB)};
            8'd40: r = {p(VI),p(VO),n(VF)};
            8'd41: r = {p(VP),p(VJ),p(V0)};
            8'd42: r = {p(VN),p(VL),p(VA)};
            8'd43: r = {p(VN),p(VL),n(VA)};
            8'd44: r = {p(VJ),p(VP),p(V0)};
            8'd45: r = {p(VG),p(VM),p(VK)};
            8'd46: r = {p(VQ),p(VH),p(VC)};
            8'd47: r = {p(VM),p(VK),p(VG)};
            8'd48: r = {p(VO),p(VF),p(VI)};
            8'd49: r = {p(VL),p(VA),p(VN)};
            8'd50: r = {p(VK),p(VG),p(VM)};
            8'd51: r = {p(VS),p(VE),p(V0)};
            8'd52: r = {p(VU),p(V0),p(V0)};
            8'd53: r = {p(VR),p(VB),p(VD)};
            8'd54: r = {p(VP),n(VJ),p(V0)};
            8'd55: r = {p(VS),n(VE),p(V0)};
            8'd56: r = {p(VQ),n(VH),p(VC)};
            8'd57: r = {p(VR),n(VB),p(VD)};
            8'd58: r = {p(VO),n(VF),p(VI)};
            8'd59: r = {p(VL),n(VA),p(VN)};
            8'd60: r = {p(VP),p(V0),p(VJ)};
            8'd61: r = {p(VQ),p(VH),n(VC)};
            8'd62: r = {p(VO),p(VF),n(VI)};
            8'd63: r = {p(VR),p(VB),n(VD)};
            8'd64: r = {p(VJ),p(V0),n(VP)};
            8'd65: r = {p(VL),p(VA),n(VN)};
            8'd66: r = {p(VL),n(VA),n(VN)};
            8'd67: r = {p(VP),p(V0),n(VJ)};
            8'd68: r = {p(VO),n(VF),n(VI)};
            8'd69: r = {p(VQ),n(VH),n(VC)};
            8'd70: r = {p(VR),n(VB),n(VD)};
            8'd71: r = {p(VA),p(VN),n(VL)};
            8'd72: r = {p(VF),p(VI),n(VO)};
            8'd73: r = {p(VG),p(VM),n(VK)};
            8'd74: r = {p(VH),p(VC),n(VQ)};
            8'd75: r = {p(VK),p(VG),n(VM)};
            8'd76: r = {p(VM),p(VK),n(VG)};
            8'd77: r = {n(VA),p(VN),n(VL)};
            8'd78: r = {n(VF),p(VI),n(VO)};
            8'd79: r = {p(V0),p(VJ),n(VP)};
            8'd80: r = {n(VJ),p(V0),n(VP)};
            8'd81: r = {n(VH),p(VC),n(VQ)};
            8'd82: r = {n(VE),p(V0),n(VS)};
            8'd83: r = {n(VB),p(VD),n(VR)};
            8'd84: r = {p(V0),p(V0),n(VU)};
            8'd85: r = {p(VE),p(V0),n(VS)};
            8'd86: r = {p(VB),p(VD),n(VR)};
            8'd87: r = {n(VH),n(VC),n(VQ)};
            8'd88: r = {n(VF),n(VI),n(VO)};
            8'd89: r = {n(VB),n(VD),n(VR)};
            8'd90: r = {p(V0),n(VP),n(VJ)};
            8'd91: r = {n(VA),n(VN),n(VL)};
            8'd92: r = {p(VA),n(VN),n(VL)};
            8'd93: r = {p(V0),n(VJ),n(VP)};
            8'd94: r = {p(VF),n(VI),n(VO)};
            8'd95: r = {p(VH),n(VC),n(VQ)};
            8'd96: r = {p(VB),n(VD),n(VR)};
            8'd97: r = {p(VC),n(VQ),n(VH)};
            8'd98: r = {p(VI),n(VO),n(VF)};
            8'd99: r = {p(VG),n(VM),n(VK)};
            8'd100: r = {p(VN),n(VL),n(VA)};
            8'd101: r = {p(VM),n(VK),n(VG)};
            8'd102: r = {p(VK),n(VG),n(VM)};
            8'd103: r = {p(V0),n(VS),n(VE)};
            8'd104: r = {p(V0),n(VU),p(V0)};
            8'd105: r = {p(VD),n(VR),n(VB)};
            8'd106: r = {p(V0),n(VP),p(VJ)};
            8'd107: r = {p(V0),n(VS),p(VE)};
            8'd108: r = {p(VC),n(VQ),p(VH)};
            8'd109: r = {p(VD),n(VR),p(VB)};
            8'd110: r = {p(VI),n(VO),p(VF)};
            8'd111: r = {p(VN),n(VL),p(VA)};
            8'd112: r = {p(VJ),n(VP),p(V0)};
            8'd113: r = {n(VC),n(VQ),n(VH)};
            8'd114: r = {n(VI),n(VO),n(VF)};
            8'd115: r = {n(VD),n(VR),n(VB)};
            8'd116: r = {n(VP),n(VJ),p(V0)};
            8'd117: r = {n(VN),n(VL),n(VA)};
            8'd118: r = {n(VN),n(VL),p(VA)};
            8'd119: r = {n(VJ),n(VP),p(V0)};
            8'd120: r = {n(VI),n(VO),p(VF)};
            8'd121: r = {n(VC),n(VQ),p(VH)};
            8'd122: r = {n(VD),n(VR),p(VB)};
            8'd123: r = {n(VQ),n(VH),p(VC)};
            8'd124: r = {n(VO),n(VF),p(VI)};
            8'd125: r = {n(VM),n(VK),p(VG)};
            8'd126: r = {n(VL),n(VA),p(VN)};
            8'd127: r = {n(VH),n(VC),p(VQ)};
            8'd128: r = {n(VK),n(VG),p(VM)};
            8'd129: r = {n(VF),n(VI),p(VO)};
            8'd130: r = {n(VA),n(VN),p(VL)};
            8'd131: r = {n(VG),n(VM),p(VK)};
            8'd132: r = {n(VB),n(VD),p(VR)};
            8'd133: r = {p(VH),n(VC),p(VQ)};
            8'd134: r = {p(VB),n(VD),p(VR)};
            8'd135: r = {p(VF),n(VI),p(VO)};
            8'd136: r = {p(VA),n(VN),p(VL)};
            8'd137: r = {p(V0),n(VJ),p(VP)};
            8'd138: r = {p(VG),n(VM),p(VK)};
            8'd139: r = {p(VK),n(VG),p(VM)};
            8'd140: r = {p(VM),n(VK),p(VG)};
            8'd141: r = {n(VS),p(VE),p(V0)};
            8'd142: r = {n(VR),p(VB),p(VD)};
            8'd143: r = {n(VU),p(V0),p(V0)};
            8'd144: r = {n(VP),p(V0),p(VJ)};
            8'd145: r = {n(VS),n(VE),p(V0)};
            8'd146: r = {n(VR),n(VB),p(VD)};
            8'd147: r = {n(VQ),p(VH),n(VC)};
            8'd148: r = {n(VR),p(VB),n(VD)};
            8'd149: r = {n(VO),p(VF),n(VI)};
            8'd150: r = {n(VQ),n(VH),n(VC)};
            8'd151: r = {n(VR),n(VB),n(VD)};
            8'd152: r = {n(VO),n(VF),n(VI)};
            8'd153: r = {n(VL),p(VA),n(VN)};
            8'd154: r = {n(VL),n(VA),n(VN)};
            8'd155: r = {n(VP),p(V0),n(VJ)};
            8'd156: r = {n(VM),p(VK),n(VG)};
            8'd157: r = {n(VK),p(VG),n(VM)};
            8'd158: r = {n(VG),p(VM),n(VK)};
            8'd159: r = {n(VG),n(VM),n(VK)};
            8'd160: r = {n(VK),n(VG),n(VM)};
            8'd161: r = {n(VM),n(VK),n(VG)};
            default: r = '0;
        endcase
        normal_lookup = r;
    endfunction

endpackage

@@ src/vdsf_front.sv @@
module vdsf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  vdsf_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  vdsf_pkg::in_item_t in_item,
    output logic               push,
    output vdsf_pkg::q_item_t  push_item,
    input  logic               q_full
);

    vdsf_pkg::fe_state_t state_reg, state_next;
    vdsf_pkg::in_item_t  item_reg;
    logic [1:0]          axis_reg, axis_next;
    logic signed [31:0]  prod_reg;
    logic signed [31:0]  wx_reg, wy_reg, wz_reg;

    logic signed [23:0]  scl;
    logic signed [31:0]  off;
    logic [7:0]          byte_sel;
    logic signed [32:0]  f;
    logic signed [32:0]  g;
    logic signed [16:0]  ip;
    logic [15:0]         ipm;
    logic [31:0]         u;
    logic signed [56:0]  pr;
    logic signed [31:0]  q;
    logic [47:0]         nrm;

    always_comb begin
        scl = cfg.scale_x;
        off = cfg.offset_x;
        byte_sel = item_reg.packed_x;
        case (axis_reg)
            2'd1: begin
                scl = cfg.scale_y; off = cfg.offset_y; byte_sel = item_reg.packed_y;
            end
            2'd2: begin
                scl = cfg.scale_z; off = cfg.offset_z; byte_sel = item_reg.packed_z;
            end
            default: begin
                scl = cfg.scale_x; off = cfg.offset_x; byte_sel = item_reg.packed_x;
            end
        endcase
        f = 33'(signed'({1'b0, byte_sel}) * scl);
    end

    // snap and offset from registered product, then recip multiply
    always_comb begin
        g = 33'(prod_reg) + 33'(signed'({1'b0, cfg.snap_step, 15'd0}));
        ip = g[32] && (g[15:0] != 16'd0) ? 17'(g[32:16] + 17'sd1) : g[32:16];
        ipm = ip[15:0] & ~(16'(cfg.snap_step) - 16'd1);
        u = (cfg.snap_step != 7'd0) ? {ipm, 16'd0} : 32'(prod_reg);
        u = u + 32'(off);
        pr = 57'(signed'(u) * signed'({1'b0, cfg.unit_recip}));
        q = pr[47:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vdsf_pkg::FE_IDLE;
            axis_reg <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg <= axis_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) item_reg <= in_item;
        if (state_reg == vdsf_pkg::FE_SCALE) prod_reg <= 32'(f);
        if (state_reg == vdsf_pkg::FE_RECIP) begin
            case (axis_reg)
                2'd1: wy_reg <= q;
                2'd2: wz_reg <= q;
                default: wx_reg <= q;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next = axis_reg;
        in_ready = 1'b0;
        push = 1'b0;
        case (state_reg)
            vdsf_pkg::FE_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = vdsf_pkg::FE_SCALE;
                    axis_next = 2'd0;
                end
            end
            vdsf_pkg::FE_SCALE: state_next = vdsf_pkg::FE_RECIP;
            vdsf_pkg::FE_RECIP: begin
                if (axis_reg == 2'd2) begin
                    state_next = vdsf_pkg::FE_PUSH;
                end else begin
                    axis_next = axis_reg + 2'd1;
                    state_next = vdsf_pkg::FE_SCALE;
                end
            end
            vdsf_pkg::FE_PUSH: begin
                if (!q_full) begin
                    push = 1'b1;
                    in_ready = 1'b1;
                    if (in_valid) begin
                        state_next = vdsf_pkg::FE_SCALE;
                        axis_next = 2'd0;
                    end else begin
                        state_next = vdsf_pkg::FE_IDLE;
                    end
                end
            end
            default: state_next = vdsf_pkg::FE_IDLE;
        endcase
    end

    always_comb begin
        nrm = vdsf_pkg::normal_lookup(item_reg.normal_index);
        push_item.first = item_reg.run_start;
        push_item.fan = item_reg.fan_mode;
        push_item.v.s = item_reg.tex_s;
        push_item.v.t = item_reg.tex_t;
        push_item.v.nx = -signed'(nrm[31:16]);
        push_item.v.ny = signed'(nrm[15:0]);
        push_item.v.nz = -signed'(nrm[47:32]);
        push_item.v.wx = -wy_reg;
        push_item.v.wy = wz_reg;
        push_item.v.wz = -wx_reg;
    end

endmodule

@@ src/vdsf_queue.sv @@
`include "assert_macros.svh"

module vdsf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vdsf_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output vdsf_pkg::q_item_t head
);

    vdsf_pkg::q_item_t mem_reg [vdsf_pkg::QDEPTH];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;

    assign full = cnt_reg == 2'(vdsf_pkg::QDEPTH);
    assign not_empty = cnt_reg != 2'd0;
    assign head = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_item;
    end

    `ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full, "push into full queue")
    `ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, not_empty, "pop from empty queue")
    `ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 2'(vdsf_pkg::QDEPTH),
                 "queue count out of range")

endmodule

@@ src/vdsf_back.sv @@
`include "assert_macros.svh"

module vdsf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  vdsf_pkg::q_item_t   q_head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output vdsf_pkg::out_item_t m_item
);

    vdsf_pkg::be_state_t state_reg, state_next;
    vdsf_pkg::vert_t     slot_reg [3];
    logic [1:0]          fill_reg, fill_next;
    logic                par_reg, par_next;
    logic                fan_reg, fan_next;
    vdsf_pkg::vert_t     cur;
    logic [1:0]          fill_eff;
    logic [1:0]          sel;

    always_comb begin
        fill_eff = q_head.first ? 2'd0 : fill_reg;
        sel = 2'd0;
        case (state_reg)
            vdsf_pkg::BE_V1: sel = (!fan_reg && par_reg) ? 2'd2 : 2'd1;
            vdsf_pkg::BE_V2: sel = (!fan_reg && par_reg) ? 2'd1 : 2'd2;
            default: sel = 2'd0;
        endcase
        cur = slot_reg[sel];
        m_item.out_s = cur.s;
        m_item.out_t = cur.t;
        m_item.normal_x = cur.nx;
        m_item.normal_y = cur.ny;
        m_item.normal_z = cur.nz;
        m_item.world_x = cur.wx;
        m_item.world_y = cur.wy;
        m_item.world_z = cur.wz;
        m_item.tri_last = state_reg == vdsf_pkg::BE_V2;
    end

    always_comb begin
        state_next = state_reg;
        fill_next = fill_reg;
        par_next = par_reg;
        fan_next = fan_reg;
        pop = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            vdsf_pkg::BE_IDLE: begin
                if (q_not_empty) begin
                    pop = 1'b1;
                    if (q_head.first) begin
                        par_next = 1'b0;
                        fan_next = q_head.fan;
                    end
                    if (fill_eff < 2'd2) fill_next = fill_eff + 2'd1;
                    else begin
                        fill_next = 2'd2;
                        state_next = vdsf_pkg::BE_V0;
                    end
                end
            end
            vdsf_pkg::BE_V0: begin
                m_valid = 1'b1;
                if (m_ready) state_next = vdsf_pkg::BE_V1;
            end
            vdsf_pkg::BE_V1: begin
                m_valid = 1'b1;
                if (m_ready) state_next = vdsf_pkg::BE_V2;
            end
            vdsf_pkg::BE_V2: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = vdsf_pkg::BE_IDLE;
                    if (!fan_reg) par_next = ~par_reg;
                end
            end
            default: state_next = vdsf_pkg::BE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vdsf_pkg::BE_IDLE;
            fill_reg <= '0;
            par_reg <= 1'b0;
            fan_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            par_reg <= par_next;
            fan_reg <= fan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) slot_reg[fill_eff] <= q_head.v;
        if (state_reg == vdsf_pkg::BE_V2 && m_ready) begin
            if (!fan_reg) slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `ASSERT_IMPL(a_pop_idle, aclk, aresetn, pop, state_reg == vdsf_pkg::BE_IDLE,
                 "pop while emitting")
    `ASSERT_NEXT(a_last_ret, aclk, aresetn, m_valid && m_ready && m_item.tri_last,
                 state_reg == vdsf_pkg::BE_IDLE, "no return after triangle")

endmodule

@@ src/vertex_decompress_strip_fan_assembly_core.sv @@
// Decompresses one vertex per input item and assembles strips and fans into a
// triangle list. The front end decodes the three coordinates through one shared
// scale multiplier and one reciprocal multiplier, a scale then a reciprocal step
// per axis; the back end then sends the three vertices of a triangle at one per
// cycle while m_ready is high. A two-entry queue between them lets decode of the
// next vertex overlap emission. Without output stalls, throughput is set by the
// front end's pass over the axes; it accepts a new item only once the last is
// pushed. Config registers are written through the cfg channel, always ready.
module vertex_decompress_strip_fan_assembly_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vdsf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vdsf_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    vdsf_pkg::cfg_t    cfg_reg;
    logic              push, q_full, pop, q_ne;
    vdsf_pkg::q_item_t push_item, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_x <= 24'sd65536;
            cfg_reg.scale_y <= 24'sd65536;
            cfg_reg.scale_z <= 24'sd65536;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.offset_z <= '0;
            cfg_reg.snap_step <= '0;
            cfg_reg.unit_recip <= 24'd65536;
        end else if (cfg_valid) begin
            case (vdsf_pkg::reg_idx_t'(cfg_index))
                vdsf_pkg::REG_SCALE_X: cfg_reg.scale_x <= cfg_data[23:0];
                vdsf_pkg::REG_SCALE_Y: cfg_reg.scale_y <= cfg_data[23:0];
                vdsf_pkg::REG_SCALE_Z: cfg_reg.scale_z <= cfg_data[23:0];
                vdsf_pkg::REG_OFFSET_X: cfg_reg.offset_x <= cfg_data;
                vdsf_pkg::REG_OFFSET_Y: cfg_reg.offset_y <= cfg_data;
                vdsf_pkg::REG_OFFSET_Z: cfg_reg.offset_z <= cfg_data;
                vdsf_pkg::REG_SNAP: cfg_reg.snap_step <= cfg_data[6:0];
                vdsf_pkg::REG_RECIP: cfg_reg.unit_recip <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    vdsf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_data),
        .push(push), .push_item(push_item), .q_full(q_full)
    );

    vdsf_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_item(push_item),
        .full(q_full), .pop(pop), .not_empty(q_ne), .head(q_head)
    );

    vdsf_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_not_empty(q_ne), .q_head(q_head),
        .pop(pop), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_data)
    );

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 40;
    localparam int NORM_COUNT = 162;

    localparam int A = 2419, B = 2662, C = 3913, D = 4307, E = 4837, F = 5063;
    localparam int G = 6969, H = 7256, I = 8192, J = 8614, K = 9630, L = 11169;
    localparam int M = 11275, N = 11740, O = 13255, P = 13937, Q = 14159;
    localparam int R = 15582, S = 15654, U = 16384;

    // unit normals {x, y, z}, q1.14
    localparam int NORM_TAB [0:NORM_COUNT-1][0:2] = '{
        '{-J,0,P},'{-H,C,Q},'{-E,0,S},'{-F,I,O},
        '{-B,D,R},'{0,0,U},'{0,P,J},'{-A,N,L},
        '{A,N,L},'{0,J,P},'{F,I,O},'{J,0,P},
        '{E,0,S},'{H,C,Q},'{B,D,R},'{-L,A,N},
        '{-O,F,I},'{-K,G,M},'{-P,J,0},'{-Q,H,C},
        '{-N,L,A},'{-M,K,G},'{-I,O,F},'{-C,Q,H},
        '{-G,M,K},'{-N,L,-A},'{-I,O,-F},'{-J,P,0},
        '{0,P,-J},'{-C,Q,-H},'{0,S,-E},'{-D,R,-B},
        '{0,U,0},'{0,S,E},'{-D,R,B},'{C,Q,H},
        '{D,R,B},'{I,O,F},'{C,Q,-H},'{D,R,-B},
        '{I,O,-F},'{P,J,0},'{N,L,A},'{N,L,-A},
        '{J,P,0},'{G,M,K},'{Q,H,C},'{M,K,G},
        '{O,F,I},'{L,A,N},'{K,G,M},'{S,E,0},
        '{U,0,0},'{R,B,D},'{P,-J,0},'{S,-E,0},
        '{Q,-H,C},'{R,-B,D},'{O,-F,I},'{L,-A,N},
        '{P,0,J},'{Q,H,-C},'{O,F,-I},'{R,B,-D},
        '{J,0,-P},'{L,A,-N},'{L,-A,-N},'{P,0,-J},
        '{O,-F,-I},'{Q,-H,-C},'{R,-B,-D},'{A,N,-L},
        '{F,I,-O},'{G,M,-K},'{H,C,-Q},'{K,G,-M},
        '{M,K,-G},'{-A,N,-L},'{-F,I,-O},'{0,J,-P},
        '{-J,0,-P},'{-H,C,-Q},'{-E,0,-S},'{-B,D,-R},
        '{0,0,-U},'{E,0,-S},'{B,D,-R},'{-H,-C,-Q},
        '{-F,-I,-O},'{-B,-D,-R},'{0,-P,-J},'{-A,-N,-L},
        '{A,-N,-L},'{0,-J,-P},'{F,-I,-O},'{H,-C,-Q},
        '{B,-D,-R},'{C,-Q,-H},'{I,-O,-F},'{G,-M,-K},
        '{N,-L,-A},'{M,-K,-G},'{K,-G,-M},'{0,-S,-E},
        '{0,-U,0},'{D,-R,-B},'{0,-P,J},'{0,-S,E},
        '{C,-Q,H},'{D,-R,B},'{I,-O,F},'{N,-L,A},
        '{J,-P,0},'{-C,-Q,-H},'{-I,-O,-F},'{-D,-R,-B},
        '{-P,-J,0},'{-N,-L,-A},'{-N,-L,A},'{-J,-P,0},
        '{-I,-O,F},'{-C,-Q,H},'{-D,-R,B},'{-Q,-H,C},
        '{-O,-F,I},'{-M,-K,G},'{-L,-A,N},'{-H,-C,Q},
        '{-K,-G,M},'{-F,-I,O},'{-A,-N,L},'{-G,-M,K},
        '{-B,-D,R},'{H,-C,Q},'{B,-D,R},'{F,-I,O},
        '{A,-N,L},'{0,-J,P},'{G,-M,K},'{K,-G,M},
        '{M,-K,G},'{-S,E,0},'{-R,B,D},'{-U,0,0},
        '{-P,0,J},'{-S,-E,0},'{-R,-B,D},'{-Q,H,-C},
        '{-R,B,-D},'{-O,F,-I},'{-Q,-H,-C},'{-R,-B,-D},
        '{-O,-F,-I},'{-L,A,-N},'{-L,-A,-N},'{-P,0,-J},
        '{-M,K,-G},'{-K,G,-M},'{-G,M,-K},'{-G,-M,-K},
        '{-K,-G,-M},'{-M,-K,-G}
    };

    class triangle_scoreboard;
        bit signed [23:0] scl [3];
        bit signed [31:0] off [3];
        bit [6:0]  snap;
        bit [23:0] recip;
        vdsf_pkg::vert_t     slot [3];
        int        fill;
        bit        parity;
        bit        fan;
        vdsf_pkg::out_item_t pending_verts [$];

        function new();
            for (int a = 0; a < 3; a++) begin
                scl[a] = 24'sd65536;
                off[a] = '0;
            end
            snap = '0;
            recip = 24'd65536;
            fill = 0;
            parity = 0;
            fan = 0;
        endfunction

        function void set_reg(vdsf_pkg::reg_idx_t r, bit [31:0] v);
            case (r)
                vdsf_pkg::REG_SCALE_X: scl[0] = v[23:0];
                vdsf_pkg::REG_SCALE_Y: scl[1] = v[23:0];
                vdsf_pkg::REG_SCALE_Z: scl[2] = v[23:0];
                vdsf_pkg::REG_OFFSET_X: off[0] = v;
                vdsf_pkg::REG_OFFSET_Y: off[1] = v;
                vdsf_pkg::REG_OFFSET_Z: off[2] = v;
                vdsf_pkg::REG_SNAP: snap = v[6:0];
                vdsf_pkg::REG_RECIP: recip = v[23:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] decode(bit [7:0] b, int a);
            longint f, g, ip, pr, q;
            bit [31:0] u, ipu;
            f = longint'(b) * longint'(scl[a]);
            if (snap != 0) begin
                g = f + (longint'(snap) << 15);
                ip = g / 64'sd65536;
                ipu = ip[31:0] & ~(32'(snap) - 32'd1);
                u = {ipu[15:0], 16'h0000};
            end else begin
                u = f[31:0];
            end
            u = u + off[a];
            pr = longint'($signed(u)) * longint'(recip);
            q = pr >>> 16;
            return q[31:0];
        endfunction

        function void push_vert(int k, bit last);
            vdsf_pkg::out_item_t o;
            o.out_s = slot[k].s;
            o.out_t = slot[k].t;
            o.normal_x = slot[k].nx;
            o.normal_y = slot[k].ny;
            o.normal_z = slot[k].nz;
            o.world_x = slot[k].wx;
            o.world_y = slot[k].wy;
            o.world_z = slot[k].wz;
            o.tri_last = last;
            pending_verts.push_back(o);
        endfunction

        function void note_input(vdsf_pkg::in_item_t it);
            vdsf_pkg::vert_t v;
            int k;
            bit [31:0] px, py, pz;
            int nrm [3];
            if (it.run_start) begin
                fill = 0;
                parity = 0;
                fan = it.fan_mode;
            end
            k = (fill < 2) ? fill : 2;
            px = decode(it.packed_x, 0);
            py = decode(it.packed_y, 1);
            pz = decode(it.packed_z, 2);
            for (int a = 0; a < 3; a++)
                nrm[a] = (it.normal_index < NORM_COUNT) ? NORM_TAB[it.normal_index][a] : 0;
            v.s = it.tex_s;
            v.t = it.tex_t;
            v.nx = 16'(-nrm[1]);
            v.ny = 16'(nrm[2]);
            v.nz = 16'(-nrm[0]);
            v.wx = 32'd0 - py;
            v.wy = pz;
            v.wz = 32'd0 - px;
            slot[k] = v;
            if (fill < 2) begin
                fill++;
                return;
            end
            push_vert(0, 0);
            if (fan) begin
                push_vert(1, 0);
                push_vert(2, 1);
                slot[1] = slot[2];
            end else begin
                if (parity) begin
                    push_vert(2, 0);
                    push_vert(1, 1);
                end else begin
                    push_vert(1, 0);
                    push_vert(2, 1);
                end
                slot[0] = slot[1];
                slot[1] = slot[2];
                parity = ~parity;
            end
        endfunction

        function bit check_vert(vdsf_pkg::out_item_t got, output string why);
            vdsf_pkg::out_item_t x;
            why = "";
            if (pending_verts.size() == 0) begin
                why = "vertex with nothing expected";
                return 0;
            end
            x = pending_verts.pop_front();
            if (got.out_s != x.out_s) why = {why, $sformatf(" s %h/%h", got.out_s, x.out_s)};
            if (got.out_t != x.out_t) why = {why, $sformatf(" t %h/%h", got.out_t, x.out_t)};
            if (got.normal_x != x.normal_x)
                why = {why, $sformatf(" nx %h/%h", got.normal_x, x.normal_x)};
            if (got.normal_y != x.normal_y)
                why = {why, $sformatf(" ny %h/%h", got.normal_y, x.normal_y)};
            if (got.normal_z != x.normal_z)
                why = {why, $sformatf(" nz %h/%h", got.normal_z, x.normal_z)};
            if (got.world_x != x.world_x)
                why = {why, $sformatf(" wx %h/%h", got.world_x, x.world_x)};
            if (got.world_y != x.world_y)
                why = {why, $sformatf(" wy %h/%h", got.world_y, x.world_y)};
            if (got.world_z != x.world_z)
                why = {why, $sformatf(" wz %h/%h", got.world_z, x.world_z)};
            if (got.tri_last != x.tri_last)
                why = {why, $sformatf(" last %b/%b", got.tri_last, x.tri_last)};
            return why == "";
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    vdsf_pkg::in_item_t  s_data;
    logic        m_valid;
    logic        m_ready;
    vdsf_pkg::out_item_t m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    triangle_scoreboard sb;
    int errors;
    int cycles;
    int stall_pct;
    int hold_cycles;

    vertex_decompress_strip_fan_assembly_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    task automatic report(string msg);
        errors++;
        $display("mismatch at cycle %0d:%s", cycles, msg);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check accepted items, then decide ready for the next edge
    always @(posedge aclk) begin
        string why;
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_vert(m_data, why))
                report(why);
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(vdsf_pkg::reg_idx_t r, bit [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(r, v);
    endtask

    task automatic write_all(bit [31:0] vals [8]);
        for (int r = 0; r < 8; r++)
            write_reg(vdsf_pkg::reg_idx_t'(r), vals[r]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_vertex(vdsf_pkg::in_item_t it, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_verts.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic vdsf_pkg::in_item_t rand_vertex(bit start, bit fan);
        vdsf_pkg::in_item_t it;
        it.run_start = start;
        it.fan_mode = fan;
        it.tex_s = 17'($urandom_range(0, 65536));
        it.tex_t = 17'($urandom_range(0, 65536));
        it.packed_x = 8'($urandom);
        it.packed_y = 8'($urandom);
        it.packed_z = 8'($urandom);
        it.normal_index = 8'($urandom);
        return it;
    endfunction

    function automatic vdsf_pkg::in_item_t make_vertex(bit start, bit fan, int s, int t,
                                                       int x, int y, int z, int ni);
        vdsf_pkg::in_item_t it;
        it.run_start = start;
        it.fan_mode = fan;
        it.tex_s = 17'(s);
        it.tex_t = 17'(t);
        it.packed_x = 8'(x);
        it.packed_y = 8'(y);
        it.packed_z = 8'(z);
        it.normal_index = 8'(ni);
        return it;
    endfunction

    // mostly whole runs with random content, some stray vertices
    task automatic random_phase(int count, int idle_pct);
        int sent;
        int len;
        bit fan;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 15) begin
                send_vertex(rand_vertex(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                            idle_pct);
                sent++;
            end else begin
                len = $urandom_range(1, 8);
                fan = 1'($urandom_range(0, 1));
                for (int k = 0; k < len; k++)
                    send_vertex(rand_vertex(k == 0, fan), idle_pct);
                sent += len;
            end
        end
    endtask

    initial begin
        bit [31:0] vals [8];
        sb = new();
        errors = 0;
        cycles = 0;
        stall_pct = 0;
        hold_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // strip from reset with no run start, then a fan over the extremes, then short strips
        send_vertex(make_vertex(0, 1, 0, 65536, 0, 255, 0, 0), 0);
        send_vertex(make_vertex(0, 0, 65536, 0, 255, 0, 255, 161), 0);
        send_vertex(make_vertex(0, 1, 12345, 54321, 128, 1, 77, 162), 0);
        send_vertex(make_vertex(0, 0, 65535, 1, 255, 255, 255, 255), 0);
        send_vertex(make_vertex(0, 0, 1, 65535, 0, 0, 0, 32), 0);
        send_vertex(make_vertex(1, 1, 100, 200, 10, 20, 30, 5), 0);
        send_vertex(make_vertex(0, 0, 65536, 65536, 255, 0, 128, 84), 0);
        send_vertex(make_vertex(0, 1, 0, 0, 0, 255, 255, 143), 0);
        send_vertex(make_vertex(0, 0, 43690, 21845, 170, 85, 15, 104), 0);
        send_vertex(make_vertex(0, 0, 21845, 43690, 85, 170, 240, 200), 0);
        send_vertex(make_vertex(1, 0, 7, 9, 1, 2, 3, 52), 0);
        send_vertex(make_vertex(0, 0, 8, 10, 4, 5, 6, 1), 0);
        send_vertex(make_vertex(1, 0, 9, 11, 250, 251, 252, 2), 0);
        drain();

        // extremes: most negative and largest scales, extreme offsets, snapping, max and zero reciprocal
        vals = '{32'hFF800000, 32'h007FFFFF, 32'h00000000, 32'h80000000,
                 32'h7FFFFFFF, 32'h00010000, 32'd1, 32'h00FFFFFF};
        write_all(vals);
        for (int k = 0; k < 8; k++)
            send_vertex(rand_vertex(k == 0, 0), 0);
        drain();
        vals = '{32'h007FFFFF, 32'hFF800000, 32'h00012345, 32'h7FFFFFFF,
                 32'h80000000, 32'hFFFF0000, 32'd64, 32'd0};
        write_all(vals);
        for (int k = 0; k < 6; k++)
            send_vertex(rand_vertex(k == 0, 1), 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            vals[0] = $urandom & 32'hFFFFFF;
            vals[1] = $urandom & 32'hFFFFFF;
            vals[2] = $urandom & 32'hFFFFFF;
            vals[3] = $urandom;
            vals[4] = $urandom;
            vals[5] = $urandom;
            vals[6] = (ph == 1) ? 32'd0 : (32'd1 << $urandom_range(0, 6));
            vals[7] = $urandom_range(0, 32'h3FFFF);
            write_all(vals);
            case (ph)
                0: begin
                    stall_pct = 0;
                    hold_cycles = 400;
                    random_phase(24, 0);
                end
                1: begin
                    stall_pct = 0;
                    random_phase(24, 82);
                end
                2: begin
                    stall_pct = 82;
                    random_phase(24, 0);
                end
                default: begin
                    stall_pct = 19;
                    random_phase(24, 19);
                end
            endcase
            drain();
            stall_pct = 0;
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/vdsf_pkg.sv
src/vdsf_front.sv
src/vdsf_queue.sv
src/vdsf_back.sv
src/vertex_decompress_strip_fan_assembly_core.sv
verif/tb.sv
